FILE: sv/fdl_pkg.sv
package fdl_pkg;

	// width of the integer delay register
	localparam int WHOLE_BITS = 12;

	// configuration register index width; wide enough to see writes past the list
	localparam int CFG_IDX_BITS = 2;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_DELAY_WHOLE = 2'd0,
		REG_DELAY_FRAC  = 2'd1
	} cfg_reg_t;

endpackage

FILE: sv/fdl_stream_if.sv
interface fdl_stream_if #(
	parameter int SAMPLE_BITS = 24
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink   (input valid, input sample, output ready);
endinterface

FILE: sv/fdl_cfg_if.sv
interface fdl_cfg_if
	import fdl_pkg::*;
#(
	parameter int DATA_BITS = 16
);
	logic                    valid;
	logic                    ready;
	logic [CFG_IDX_BITS-1:0] index;
	logic [DATA_BITS-1:0]    wdata;

	modport source (output valid, output index, output wdata, input ready);
	modport sink   (input valid, input index, input wdata, output ready);
endinterface

FILE: sv/fractional_delay_line.sv
// Channel     Role  Payload          Transaction when
// sample_in   sink  sample (signed)  valid && ready
// sample_out  src   sample (signed)  valid && ready
// cfg         sink  index, wdata     valid && ready (ready always high)
//
// One sample per cycle sustained while sample_out is ready; three register stages
// (memory read, multiply, round and saturate), and sample_out goes valid once
// an accepted sample has passed through all three.
// The ring buffer is one memory with one write and two read ports per cycle.
// After reset no sweep runs: a fill count makes taps older than the stored
// history read as zero, so the block accepts samples from the first cycle.
// A stall on sample_out backs up stage by stage; sample_in.ready drops only
// once every stage holds a transaction.
module fractional_delay_line
	import fdl_pkg::*;
#(
	parameter int DEPTH       = 4096,
	parameter int SAMPLE_BITS = 24,
	parameter int FRAC_BITS   = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	fdl_stream_if.sink   sample_in,
	fdl_stream_if.source sample_out,
	fdl_cfg_if.sink      cfg
);

	localparam int AW     = $clog2(DEPTH);
	localparam int FW     = $clog2(DEPTH + 1);
	localparam int CW     = (AW + 1 > WHOLE_BITS) ? AW + 1 : WHOLE_BITS;
	localparam int PROD_W = SAMPLE_BITS + FRAC_BITS + 2;
	localparam int SUM_W  = SAMPLE_BITS + FRAC_BITS + 3;

	localparam logic [CW-1:0]  MAX_WHOLE = CW'(DEPTH - 2);
	localparam logic [AW:0]    DEPTH_W   = (AW + 1)'(DEPTH);
	localparam logic [AW-1:0]  LAST_ADDR = AW'(DEPTH - 1);
	localparam logic [FW-1:0]  FILL_MAX  = FW'(DEPTH);
	localparam logic signed [SUM_W-1:0] SAT_HI =
		SUM_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
	localparam logic signed [SUM_W-1:0] SAT_LO = -SAT_HI - SUM_W'(1);
	localparam logic signed [SUM_W-1:0] HALF   = SUM_W'(64'sd1 <<< (FRAC_BITS - 1));

	logic [WHOLE_BITS-1:0] whole_q;
	logic [FRAC_BITS-1:0]  frac_q;
	logic [AW-1:0]         wp_q;
	logic [FW-1:0]         fill_q;

	logic [SAMPLE_BITS-1:0] mem [DEPTH];

	logic v1_s1, v2_s2, v3_s3;
	logic en1, en2, en3, acc;

	assign en3 = !v3_s3 || sample_out.ready;
	assign en2 = !v2_s2 || en3;
	assign en1 = !v1_s1 || en2;
	assign acc = sample_in.valid && en1;

	assign sample_in.ready = en1;
	assign cfg.ready       = 1'b1;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			whole_q <= '0;
			frac_q  <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_DELAY_WHOLE: whole_q <= cfg.wdata[WHOLE_BITS-1:0];
				REG_DELAY_FRAC:  frac_q  <= cfg.wdata[FRAC_BITS-1:0];
				default: ;
			endcase
		end
	end

	// tap addresses; clamp so that both taps lie in the stored history
	logic [CW-1:0] whole_ext;
	logic [AW-1:0] back_near, back_far, addr_near, addr_far;
	logic          ok_near, ok_far;

	assign whole_ext = CW'(whole_q);
	assign back_near = (whole_ext > MAX_WHOLE) ? MAX_WHOLE[AW-1:0] : whole_ext[AW-1:0];
	assign back_far  = back_near + AW'(1);

	function automatic logic [AW-1:0] tap_addr(logic [AW-1:0] wp, logic [AW-1:0] back);
		logic [AW:0] diff;
		diff = {1'b0, wp} - {1'b0, back};
		if (wp < back)
			diff = diff + DEPTH_W;
		return diff[AW-1:0];
	endfunction

	assign addr_near = tap_addr(wp_q, back_near);
	assign addr_far  = tap_addr(wp_q, back_far);

	// a tap is written history when it is no older than the fill count allows
	assign ok_near = FW'(back_near) <= fill_q;
	assign ok_far  = FW'(back_far) <= fill_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= '0;
			fill_q <= '0;
		end else if (acc) begin
			wp_q <= (wp_q == LAST_ADDR) ? '0 : wp_q + AW'(1);
			if (fill_q < FILL_MAX)
				fill_q <= fill_q + FW'(1);
		end
	end

	// stage 1: memory access
	logic [SAMPLE_BITS-1:0] rd_near_s1, rd_far_s1, smp_s1;
	logic [FRAC_BITS-1:0]   frac_s1;
	logic                   fwd_s1, ok_near_s1, ok_far_s1;

	always_ff @(posedge clk) begin
		if (acc)
			mem[wp_q] <= sample_in.sample;
		if (en1) begin
			rd_near_s1 <= mem[addr_near];
			rd_far_s1  <= mem[addr_far];
			smp_s1     <= sample_in.sample;
			frac_s1    <= frac_q;
			// the near tap is the sample being written this cycle
			fwd_s1     <= back_near == '0;
			ok_near_s1 <= ok_near;
			ok_far_s1  <= ok_far;
		end
	end

	// stage 2: (far - near)*f, with near kept for near*2^F + (far - near)*f in stage 3
	logic signed [SAMPLE_BITS-1:0] near_sel, far_sel;
	logic signed [SAMPLE_BITS:0]   diff;
	logic signed [SAMPLE_BITS-1:0] near_s2;
	logic signed [PROD_W-1:0]      prod_s2;

	assign near_sel = fwd_s1 ? $signed(smp_s1) :
		(ok_near_s1 ? $signed(rd_near_s1) : '0);
	assign far_sel  = ok_far_s1 ? $signed(rd_far_s1) : '0;
	assign diff     = (SAMPLE_BITS + 1)'(far_sel) - (SAMPLE_BITS + 1)'(near_sel);

	always_ff @(posedge clk) begin
		if (en2) begin
			near_s2 <= near_sel;
			prod_s2 <= PROD_W'(diff) * PROD_W'($signed({1'b0, frac_s1}));
		end
	end

	// stage 3: round, floor shift and saturate
	logic signed [SUM_W-1:0] sum, shifted;
	logic signed [SAMPLE_BITS-1:0] out_s3;

	assign sum     = (SUM_W'(near_s2) <<< FRAC_BITS) + SUM_W'(prod_s2) + HALF;
	assign shifted = sum >>> FRAC_BITS;

	always_ff @(posedge clk) begin
		if (en3) begin
			if (shifted > SAT_HI)
				out_s3 <= SAT_HI[SAMPLE_BITS-1:0];
			else if (shifted < SAT_LO)
				out_s3 <= SAT_LO[SAMPLE_BITS-1:0];
			else
				out_s3 <= shifted[SAMPLE_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
			v2_s2 <= 1'b0;
			v3_s3 <= 1'b0;
		end else begin
			if (en1)
				v1_s1 <= sample_in.valid;
			if (en2)
				v2_s2 <= v1_s1;
			if (en3)
				v3_s3 <= v2_s2;
		end
	end

	assign sample_out.valid  = v3_s3;
	assign sample_out.sample = out_s3;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_MAX)
		else $error("fill count past depth");

	a_wp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		wp_q <= LAST_ADDR)
		else $error("write pointer out of range");

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> v1_s1)
		else $error("accepted transaction lost at stage 1");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v1_s1 && !en2 |=> v1_s1 && $stable(rd_near_s1) && $stable(rd_far_s1))
		else $error("stage 1 dropped a stalled transaction");

	a_s2_to_s3: assert property (@(posedge clk) disable iff (!arst_n)
		v2_s2 && en3 |=> v3_s3)
		else $error("stage 2 transaction not passed on");

endmodule
